@@ src/cic_pkg.sv @@
// Shared types, constants and the priority pick for the cascaded interrupt controller.
package cic_pkg;

  localparam int unsigned LinesPerChip = 8;
  localparam int unsigned LineW        = $clog2(LinesPerChip);
  localparam int unsigned NumChips     = 2;

  localparam logic [7:0]       CmdNonSpecEoi = 8'h20;
  localparam int unsigned      CmdSetupBit   = 4;
  localparam int unsigned      CmdFourthBit  = 0;
  localparam logic [LineW-1:0] CascadeLine   = LineW'(2);
  localparam logic [LineW-1:0] SpuriousLine  = LineW'(LinesPerChip - 1);
  localparam logic             ChipMaster    = 1'b0;
  localparam logic             ChipSlave     = 1'b1;
  localparam logic             PortCmd       = 1'b0;
  localparam logic             PortData      = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RAISE = 2'd2,
    OP_ACK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STEP_READY   = 2'd0,
    STEP_BASE    = 2'd1,
    STEP_CASCADE = 2'd2,
    STEP_FOURTH  = 2'd3
  } step_e;

  typedef struct packed {
    logic             hit;
    logic [LineW-1:0] line;
  } pick_t;

  // lowest requesting line not blocked by an in-service bit at the same or a lower line
  function automatic pick_t pick_line(logic [LinesPerChip-1:0] req,
                                      logic [LinesPerChip-1:0] isr);
    pick_t r;
    logic  stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < LinesPerChip; i++) begin
      if (!stop) begin
        if (isr[i]) begin
          stop = 1'b1;
        end else if (req[i]) begin
          r.hit  = 1'b1;
          r.line = LineW'(i);
          stop   = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

@@ src/cascaded_interrupt_controller.sv @@
// Cascaded master/slave interrupt controller pair with valid/ready transaction channels.
//
// Input channel: in_valid_i/in_ready_o carry one transaction per item: a port write,
// a port read, a line raise or a CPU acknowledge (op_i), with chip, port, data and
// line fields. Output channel: out_valid_o/out_ready_i return exactly one result per
// input transaction, in order: read data, request level after the item, acknowledge
// vector, acknowledge flag and spurious flag.
// Timing: an accepted transaction is captured in the input register, and is processed
// into the result register and state once the result register is free or being taken;
// its result is offered from then on.
// Throughput: one transaction per cycle while results are taken; the controller state
// update and the eight-line priority picks sit between the input and result registers.
// When the receiver stalls, the result register holds; the input register still takes
// one more transaction, after which in_ready_o drops until the result is taken.
// Reset: both chips come up with nothing pending or in service, all lines masked,
// vector base zero and setup idle; both pipeline stages are emptied.
module cascaded_interrupt_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic       chip_sel_i,
  input  logic       port_sel_i,
  input  logic [7:0] write_data_i,
  input  logic [3:0] irq_line_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       int_out_o,
  output logic [7:0] vector_o,
  output logic       ack_valid_o,
  output logic       spurious_o
);

  localparam int unsigned L  = cic_pkg::LinesPerChip;
  localparam int unsigned LW = cic_pkg::LineW;
  localparam int unsigned NC = cic_pkg::NumChips;

  // input stage
  logic                in_valid_q;
  cic_pkg::op_e        op_q;
  logic                chip_q;
  logic                port_q;
  logic [7:0]          data_q;
  logic [3:0]          line_q;

  // controller state
  logic [L-1:0]        pend_q   [NC];
  logic [L-1:0]        pend_d   [NC];
  logic [L-1:0]        isr_q    [NC];
  logic [L-1:0]        isr_d    [NC];
  logic [L-1:0]        mask_q   [NC];
  logic [L-1:0]        mask_d   [NC];
  logic [7-LW:0]       base_q   [NC];
  logic [7-LW:0]       base_d   [NC];
  cic_pkg::step_e      step_q   [NC];
  cic_pkg::step_e      step_d   [NC];
  logic [NC-1:0]       ic4_q;
  logic [NC-1:0]       ic4_d;

  // result stage
  logic                out_valid_q;
  logic [7:0]          rd_q, rd_d;
  logic                int_q, int_d;
  logic [7:0]          vec_q, vec_d;
  logic                ackv_q, ackv_d;
  logic                spur_q, spur_d;

  logic                advance;
  cic_pkg::pick_t      s_pick, m_pick, s_pick_n, m_pick_n;
  logic [L-1:0]        m_eff, m_eff_n;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= cic_pkg::op_e'(op_i);
      chip_q <= chip_sel_i;
      port_q <= port_sel_i;
      data_q <= write_data_i;
      line_q <= irq_line_i;
    end
  end

  // picks on the current state
  always_comb begin
    s_pick = cic_pkg::pick_line(pend_q[cic_pkg::ChipSlave] & ~mask_q[cic_pkg::ChipSlave],
                                isr_q[cic_pkg::ChipSlave]);
    m_eff  = pend_q[cic_pkg::ChipMaster];
    if (s_pick.hit) begin
      m_eff[cic_pkg::CascadeLine] = 1'b1;
    end
    m_pick = cic_pkg::pick_line(m_eff & ~mask_q[cic_pkg::ChipMaster],
                                isr_q[cic_pkg::ChipMaster]);
  end

  always_comb begin
    pend_d = pend_q;
    isr_d  = isr_q;
    mask_d = mask_q;
    base_d = base_q;
    step_d = step_q;
    ic4_d  = ic4_q;
    rd_d   = '0;
    vec_d  = '0;
    ackv_d = 1'b0;
    spur_d = 1'b0;
    case (op_q)
      cic_pkg::OP_WRITE: begin
        if (port_q == cic_pkg::PortCmd) begin
          if (data_q[cic_pkg::CmdSetupBit]) begin
            ic4_d[chip_q]  = data_q[cic_pkg::CmdFourthBit];
            pend_d[chip_q] = '0;
            isr_d[chip_q]  = '0;
            mask_d[chip_q] = '0;
            step_d[chip_q] = cic_pkg::STEP_BASE;
          end else if (data_q == cic_pkg::CmdNonSpecEoi) begin
            isr_d[chip_q] = isr_q[chip_q] & (isr_q[chip_q] - L'(1));
          end
        end else begin
          case (step_q[chip_q])
            cic_pkg::STEP_BASE: begin
              base_d[chip_q] = data_q[7:LW];
              step_d[chip_q] = cic_pkg::STEP_CASCADE;
            end
            cic_pkg::STEP_CASCADE: begin
              step_d[chip_q] = ic4_q[chip_q] ? cic_pkg::STEP_FOURTH : cic_pkg::STEP_READY;
            end
            cic_pkg::STEP_FOURTH: begin
              step_d[chip_q] = cic_pkg::STEP_READY;
            end
            default: begin
              mask_d[chip_q] = data_q;
            end
          endcase
        end
      end
      cic_pkg::OP_READ: begin
        if (port_q == cic_pkg::PortData) begin
          rd_d = mask_q[chip_q];
        end else if (chip_q == cic_pkg::ChipMaster) begin
          rd_d = m_eff;
        end else begin
          rd_d = pend_q[cic_pkg::ChipSlave];
        end
      end
      cic_pkg::OP_RAISE: begin
        if (line_q[3]) begin
          pend_d[cic_pkg::ChipSlave][line_q[LW-1:0]] = 1'b1;
        end else if (line_q[LW-1:0] != cic_pkg::CascadeLine) begin
          pend_d[cic_pkg::ChipMaster][line_q[LW-1:0]] = 1'b1;
        end
      end
      default: begin
        ackv_d = 1'b1;
        if (!m_pick.hit) begin
          vec_d  = {base_q[cic_pkg::ChipMaster], cic_pkg::SpuriousLine};
          spur_d = 1'b1;
        end else if (m_pick.line != cic_pkg::CascadeLine) begin
          isr_d[cic_pkg::ChipMaster][m_pick.line]  = 1'b1;
          pend_d[cic_pkg::ChipMaster][m_pick.line] = 1'b0;
          vec_d = {base_q[cic_pkg::ChipMaster], m_pick.line};
        end else begin
          isr_d[cic_pkg::ChipMaster][cic_pkg::CascadeLine] = 1'b1;
          if (!s_pick.hit) begin
            vec_d  = {base_q[cic_pkg::ChipSlave], cic_pkg::SpuriousLine};
            spur_d = 1'b1;
          end else begin
            isr_d[cic_pkg::ChipSlave][s_pick.line]  = 1'b1;
            pend_d[cic_pkg::ChipSlave][s_pick.line] = 1'b0;
            vec_d = {base_q[cic_pkg::ChipSlave], s_pick.line};
          end
        end
      end
    endcase
  end

  // request level after the transaction
  always_comb begin
    s_pick_n = cic_pkg::pick_line(pend_d[cic_pkg::ChipSlave] & ~mask_d[cic_pkg::ChipSlave],
                                  isr_d[cic_pkg::ChipSlave]);
    m_eff_n  = pend_d[cic_pkg::ChipMaster];
    if (s_pick_n.hit) begin
      m_eff_n[cic_pkg::CascadeLine] = 1'b1;
    end
    m_pick_n = cic_pkg::pick_line(m_eff_n & ~mask_d[cic_pkg::ChipMaster],
                                  isr_d[cic_pkg::ChipMaster]);
    int_d    = m_pick_n.hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NC; c++) begin
        pend_q[c] <= '0;
        isr_q[c]  <= '0;
        mask_q[c] <= '1;
        base_q[c] <= '0;
        step_q[c] <= cic_pkg::STEP_READY;
      end
      ic4_q <= '0;
    end else if (advance) begin
      pend_q <= pend_d;
      isr_q  <= isr_d;
      mask_q <= mask_d;
      base_q <= base_d;
      step_q <= step_d;
      ic4_q  <= ic4_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rd_q   <= rd_d;
      int_q  <= int_d;
      vec_q  <= vec_d;
      ackv_q <= ackv_d;
      spur_q <= spur_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rd_q;
  assign int_out_o   = int_q;
  assign vector_o    = vec_q;
  assign ack_valid_o = ackv_q;
  assign spurious_o  = spur_q;

  a_spur_is_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && spurious_o |-> ack_valid_o)
    else $error("spurious flag without acknowledge");

  a_spur_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && spurious_o |-> vector_o[LW-1:0] == cic_pkg::SpuriousLine)
    else $error("spurious vector not on lowest-priority line");

  a_ack_sets_isr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && op_q == cic_pkg::OP_ACK && !spur_d |=> isr_q[cic_pkg::ChipMaster] != '0)
    else $error("served acknowledge left master in-service empty");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(op_q) && $stable(data_q))
    else $error("stalled input stage lost its transaction");

endmodule
